FILE: rtl/gmp_pkg.sv
`default_nettype none
package gmp_pkg;

	localparam int unsigned SCORE_W = 22;
	localparam int unsigned CFG_W = 7;
	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
	localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(64);

	// Position flags of the cell being scored.
	typedef struct packed {
		logic first_row;
		logic has_left;
		logic has_right;
	} cell_pos_t;

endpackage
`default_nettype wire

FILE: rtl/gmp_item_if.sv
`default_nettype none
interface gmp_item_if #(
	parameter int unsigned PROFIT_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [PROFIT_BITS-1:0] profit;

	modport source (output valid, output profit, input ready);
	modport sink (input valid, input profit, output ready);
endinterface
`default_nettype wire

FILE: rtl/gmp_result_if.sv
`default_nettype none
interface gmp_result_if;
	logic                        valid;
	logic                        ready;
	logic [gmp_pkg::SCORE_W-1:0] cell_best;
	logic [gmp_pkg::SCORE_W-1:0] board_best;
	logic                        board_done;

	modport source (output valid, output cell_best, output board_best, output board_done,
		input ready);
	modport sink (input valid, input cell_best, input board_best, input board_done,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/gmp_cfg_if.sv
`default_nettype none
interface gmp_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [gmp_pkg::CFG_W-1:0] board_size;

	modport source (output valid, output board_size, input ready);
	modport sink (input valid, input board_size, output ready);
endinterface
`default_nettype wire

FILE: rtl/grid_max_path_sum_dp_unit.sv
`default_nettype none
// A result is registered and presented in the cycle after its cell transaction is accepted.
// Throughput: one cell per cycle while the result is taken; the previous-row memory is read
// one cell ahead, so the next cell can follow in the very next cycle.
// Reset (arst_n low, asynchronous): board_size returns to 64, the board restarts at
// row 0, column 0, and no result is pending. The row memory is not cleared.
module grid_max_path_sum_dp_unit #(
	parameter int unsigned MAX_SIDE = 64,
	parameter int unsigned PROFIT_BITS = 16
) (
	input wire logic      clk,
	input wire logic      arst_n,
	gmp_item_if.sink      item,
	gmp_result_if.source  result,
	gmp_cfg_if.sink       cfg
);
	localparam int unsigned SW = gmp_pkg::SCORE_W;
	localparam int unsigned IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int unsigned CMP_W = (SIDE_W > gmp_pkg::CFG_W) ? SIDE_W : gmp_pkg::CFG_W;

	logic [gmp_pkg::CFG_W-1:0] size_q;
	logic [IDX_W-1:0]          row_q;
	logic [IDX_W-1:0]          col_q;
	logic [SW-1:0]             last_best_q;
	logic [SW-1:0]             up_q;
	logic [SW-1:0]             left_q;
	logic [SW-1:0]             row_first_q;
	logic [SW-1:0]             byp_q;
	logic                      byp_sel_q;
	logic                      res_valid_q;
	logic [SW-1:0]             res_cell_q;
	logic [SW-1:0]             res_board_q;
	logic                      res_done_q;

	logic [SIDE_W-1:0]  side;
	logic [CMP_W-1:0]   size_ext;
	logic               accept;
	logic               row_last;
	logic               col_last;
	logic               done;
	logic               right_ok;
	gmp_pkg::cell_pos_t pos;
	logic [SW-1:0]      ram_rdata;
	logic [SW-1:0]      right;
	logic [SW-1:0]      best;
	logic [SW-1:0]      board_best;
	logic [IDX_W-1:0]   rd_addr;

	assign size_ext = CMP_W'(size_q);

	always_comb begin
		if (size_q == '0) begin
			side = SIDE_W'(1);
		end else if (size_ext > CMP_W'(MAX_SIDE)) begin
			side = SIDE_W'(MAX_SIDE);
		end else begin
			side = SIDE_W'(size_ext);
		end
	end

	assign accept = item.valid && item.ready;
	assign row_last = (SIDE_W'(row_q) + SIDE_W'(1)) == side;
	assign col_last = (SIDE_W'(col_q) + SIDE_W'(1)) == side;
	assign done = row_last && col_last;
	assign right_ok = (SIDE_W'(col_q) + SIDE_W'(1)) < side;

	assign pos.first_row = (row_q == '0);
	assign pos.has_left = (col_q != '0);
	assign pos.has_right = right_ok;

	assign right = byp_sel_q ? byp_q : ram_rdata;

	// The memory fetches the upper-right score of the next cell: two columns ahead
	// within a row, column 1 at a row change. On a two-column board that score is
	// the one being written now, so it is taken from the bypass register instead.
	always_comb begin
		rd_addr = '0;
		if (!col_last) begin
			if (((SIDE_W + 1)'(col_q) + (SIDE_W + 1)'(2)) < (SIDE_W + 1)'(side)) begin
				rd_addr = IDX_W'(SIDE_W'(col_q) + SIDE_W'(2));
			end
		end else if ((SIDE_W + 1)'(side) >= (SIDE_W + 1)'(3)) begin
			rd_addr = IDX_W'(1);
		end
	end

	gmp_score #(
		.PROFIT_BITS(PROFIT_BITS)
	) u_score (
		.profit(item.profit),
		.pos   (pos),
		.up    (up_q),
		.left  (left_q),
		.right (right),
		.best  (best)
	);

	gmp_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_SIDE)
	) u_row_ram (
		.clk  (clk),
		.we   (accept),
		.waddr(col_q),
		.wdata(best),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		board_best = last_best_q;
		if ((col_q == '0) || (best > last_best_q)) begin
			board_best = best;
		end
	end

	assign cfg.ready = 1'b1;
	assign item.ready = !res_valid_q || result.ready;
	assign result.valid = res_valid_q;
	assign result.cell_best = res_cell_q;
	assign result.board_best = res_board_q;
	assign result.board_done = res_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= gmp_pkg::SIZE_RESET;
			row_q <= '0;
			col_q <= '0;
			last_best_q <= '0;
			byp_sel_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				size_q <= cfg.board_size;
				row_q <= '0;
				col_q <= '0;
				last_best_q <= '0;
			end else if (accept) begin
				if (done) begin
					row_q <= '0;
					col_q <= '0;
					last_best_q <= '0;
				end else if (col_last) begin
					row_q <= row_q + IDX_W'(1);
					col_q <= '0;
				end else begin
					col_q <= col_q + IDX_W'(1);
				end
				if (row_last && !done) begin
					last_best_q <= board_best;
				end
			end
			if (accept) begin
				byp_sel_q <= col_last && (side == SIDE_W'(2));
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q <= up_q;
			byp_q <= best;
			if (col_q == '0) begin
				row_first_q <= best;
			end
			if (!col_last) begin
				up_q <= right;
			end else if (col_q == '0) begin
				up_q <= best;
			end else begin
				up_q <= row_first_q;
			end
			res_cell_q <= best;
			res_board_q <= done ? board_best : '0;
			res_done_q <= done;
		end
	end

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.valid)
		else $error("Accepted cell transaction produced no result.");

	a_board_best_covers_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.board_done) |-> (result.board_best >= result.cell_best))
		else $error("Board maximum is below the final cell score.");

	a_board_best_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.board_done) |-> (result.board_best == '0))
		else $error("Board maximum shown before the final cell.");

	a_position_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(SIDE_W'(col_q) < side) && (SIDE_W'(row_q) < side))
		else $error("Cell position lies outside the board.");
endmodule
`default_nettype wire

FILE: rtl/gmp_ram.sv
`default_nettype none
module gmp_ram #(
	parameter int unsigned WIDTH = 22,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/gmp_score.sv
`default_nettype none
module gmp_score #(
	parameter int unsigned PROFIT_BITS = 16
) (
	input  wire logic [PROFIT_BITS-1:0]      profit,
	input  wire gmp_pkg::cell_pos_t          pos,
	input  wire logic [gmp_pkg::SCORE_W-1:0] up,
	input  wire logic [gmp_pkg::SCORE_W-1:0] left,
	input  wire logic [gmp_pkg::SCORE_W-1:0] right,
	output logic      [gmp_pkg::SCORE_W-1:0] best
);
	localparam int unsigned SUM_W =
		((PROFIT_BITS > gmp_pkg::SCORE_W) ? PROFIT_BITS : gmp_pkg::SCORE_W) + 1;

	logic [gmp_pkg::SCORE_W-1:0] m;
	logic [SUM_W-1:0]            sum;

	// The best reachable neighbor of the previous row; row 0 starts from zero.
	always_comb begin
		m = up;
		if (pos.has_left && (left > m)) begin
			m = left;
		end
		if (pos.has_right && (right > m)) begin
			m = right;
		end
		if (pos.first_row) begin
			m = '0;
		end
		sum = SUM_W'(m) + SUM_W'(profit);
		if (sum > SUM_W'(gmp_pkg::SCORE_MAX)) begin
			best = gmp_pkg::SCORE_MAX;
		end else begin
			best = sum[gmp_pkg::SCORE_W-1:0];
		end
	end
endmodule
`default_nettype wire

FILE: tb/tb_grid_max_path_sum_dp_unit.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_grid_max_path_sum_dp_unit;

	localparam int unsigned SIDE_LIMIT = 64;
	localparam int unsigned FULL_SIDE = 20;
	localparam int unsigned RANDOM_CELLS = 1300;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 64;
	localparam int unsigned DIR_N = 31;

	typedef struct packed {
		logic [gmp_pkg::SCORE_W-1:0] cell_best;
		logic [gmp_pkg::SCORE_W-1:0] board_best;
		logic                        board_done;
	} cell_result_t;

	typedef struct packed {
		logic                      is_size;
		logic [gmp_pkg::CFG_W-1:0] size;
		logic [15:0]               profit;
		logic                      typed;
		cell_result_t              want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	gmp_item_if #(.PROFIT_BITS(16)) item_ch();
	gmp_result_if result_ch();
	gmp_cfg_if cfg_ch();

	grid_max_path_sum_dp_unit #(
		.MAX_SIDE(SIDE_LIMIT),
		.PROFIT_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	logic [gmp_pkg::CFG_W-1:0]   size_reg;
	logic [gmp_pkg::SCORE_W-1:0] row_scores [SIDE_LIMIT];
	logic [gmp_pkg::SCORE_W-1:0] left_score;
	logic [gmp_pkg::SCORE_W-1:0] last_row_max;
	int unsigned                 cur_row;
	int unsigned                 cur_col;

	cell_result_t pending_scores [$];
	int unsigned  errors;
	int unsigned  cells_sent;
	int unsigned  tx_gap_max;
	int unsigned  rx_gap_max;
	int unsigned  quiet_cycles;
	bit           hold_req;

	dir_row_t dir_rows [DIR_N] = '{
		'{1'b0, 7'd0, 16'd0, 1'b1, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'hFFFF, 1'b1, '{22'd65535, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'h8001, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b1, 7'd1, 16'd0, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd0, 1'b1, '{22'd0, 22'd0, 1'b1}},
		'{1'b0, 7'd0, 16'hFFFF, 1'b1, '{22'd65535, 22'd65535, 1'b1}},
		'{1'b0, 7'd0, 16'h5555, 1'b1, '{22'h5555, 22'h5555, 1'b1}},
		'{1'b0, 7'd0, 16'hAAAA, 1'b1, '{22'hAAAA, 22'hAAAA, 1'b1}},
		'{1'b1, 7'd0, 16'd0, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'h1234, 1'b1, '{22'h1234, 22'h1234, 1'b1}},
		'{1'b1, 7'd2, 16'd0, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd10, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd20, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd30, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd5, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b1, 7'd3, 16'd0, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd7, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd7, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd7, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd4, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd4, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd4, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd1, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd2, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd1, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b1, 7'd127, 16'd0, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'hFFFF, 1'b1, '{22'd65535, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd3, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b1, 7'd65, 16'd0, 1'b0, '{22'd0, 22'd0, 1'b0}},
		'{1'b0, 7'd0, 16'd1, 1'b1, '{22'd1, 22'd0, 1'b0}},
		'{1'b1, 7'd64, 16'd0, 1'b0, '{22'd0, 22'd0, 1'b0}}
	};

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int unsigned side_of(input logic [gmp_pkg::CFG_W-1:0] size);
		int unsigned n;
		n = size;
		if (n == 0) begin
			n = 1;
		end
		if (n > SIDE_LIMIT) begin
			n = SIDE_LIMIT;
		end
		return n;
	endfunction

	function automatic cell_result_t score_cell(input logic [15:0] profit);
		int unsigned                 n;
		int unsigned                 r;
		int unsigned                 c;
		logic [gmp_pkg::SCORE_W-1:0] m;
		logic [gmp_pkg::SCORE_W:0]   sum;
		logic [gmp_pkg::SCORE_W-1:0] best;
		cell_result_t                res;
		n = side_of(size_reg);
		r = cur_row;
		c = cur_col;
		if (r >= n || c >= n) begin
			r = 0;
			c = 0;
		end
		if (r == 0) begin
			sum = (gmp_pkg::SCORE_W + 1)'(profit);
		end else begin
			m = row_scores[c];
			if (c > 0 && left_score > m) begin
				m = left_score;
			end
			if (c + 1 < n && row_scores[c + 1] > m) begin
				m = row_scores[c + 1];
			end
			sum = {1'b0, m} + (gmp_pkg::SCORE_W + 1)'(profit);
		end
		best = (sum > {1'b0, gmp_pkg::SCORE_MAX}) ? gmp_pkg::SCORE_MAX :
			sum[gmp_pkg::SCORE_W-1:0];
		left_score = row_scores[c];
		row_scores[c] = best;
		if (r + 1 == n && (c == 0 || best > last_row_max)) begin
			last_row_max = best;
		end
		res.cell_best = best;
		res.board_done = (r + 1 == n) && (c + 1 == n);
		res.board_best = res.board_done ? last_row_max : '0;
		if (res.board_done) begin
			cur_row = 0;
			cur_col = 0;
			last_row_max = '0;
		end else if (c + 1 == n) begin
			cur_row = r + 1;
			cur_col = 0;
		end else begin
			cur_row = r;
			cur_col = c + 1;
		end
		return res;
	endfunction

	function automatic logic [15:0] rand_profit();
		int unsigned k;
		k = $urandom_range(0, 19);
		if (k < 2) begin
			return 16'd0;
		end else if (k < 4) begin
			return 16'hFFFF;
		end else if (k < 7) begin
			return 16'($urandom_range(0, 3));
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic wait_idle();
		while (pending_scores.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	task automatic write_size(input logic [gmp_pkg::CFG_W-1:0] size);
		item_ch.valid <= 1'b0;
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.board_size <= size;
		do @(posedge clk); while (!cfg_ch.ready);
		size_reg = size;
		cur_row = 0;
		cur_col = 0;
		last_row_max = '0;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic push_cell(input logic [15:0] profit, input logic typed,
		input cell_result_t want);
		int unsigned  gap;
		cell_result_t predicted;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.profit <= profit;
		do @(posedge clk); while (!item_ch.ready);
		predicted = score_cell(profit);
		pending_scores.push_back(typed ? want : predicted);
		cells_sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin : check_results
		cell_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_scores.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result: cell_best=%0d board_best=%0d board_done=%0d",
						result_ch.cell_best, result_ch.board_best, result_ch.board_done);
				end
			end else begin
				want = pending_scores.pop_front();
				if (result_ch.cell_best !== want.cell_best ||
					result_ch.board_best !== want.board_best ||
					result_ch.board_done !== want.board_done) begin
					errors++;
					if (errors <= 10) begin
						$display("expected cell_best=%0d board_best=%0d board_done=%0d, got %0d %0d %0d",
							want.cell_best, want.board_best, want.board_done,
							result_ch.cell_best, result_ch.board_best, result_ch.board_done);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
			(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("grid_max_path_sum_dp_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int unsigned stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				stall = $urandom_range(0, rx_gap_max);
				if (stall > 0) begin
					result_ch.ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			@(negedge clk);
		end
	end

	initial begin
		logic [gmp_pkg::CFG_W-1:0] size;
		int unsigned               eff;
		int unsigned               count;
		int unsigned               boards;
		int unsigned               k;
		bit                        first_phase;
		cell_result_t              none;
		none = '0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.profit = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.board_size = '0;
		hold_req = 1'b0;
		errors = 0;
		cells_sent = 0;
		quiet_cycles = 0;
		tx_gap_max = 12;
		rx_gap_max = 12;
		size_reg = gmp_pkg::SIZE_RESET;
		cur_row = 0;
		cur_col = 0;
		left_score = '0;
		last_row_max = '0;
		for (int i = 0; i < SIDE_LIMIT; i++) begin
			row_scores[i] = '0;
		end
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			if (dir_rows[i].is_size) begin
				write_size(dir_rows[i].size);
			end else begin
				push_cell(dir_rows[i].profit, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		cells_sent = 0;
		first_phase = 1'b1;
		while (cells_sent < RANDOM_CELLS) begin
			k = $urandom_range(0, 19);
			if (k < 13) begin
				size = gmp_pkg::CFG_W'($urandom_range(1, 8));
			end else if (k < 17) begin
				size = gmp_pkg::CFG_W'($urandom_range(9, 20));
			end else if (k < 19) begin
				size = gmp_pkg::CFG_W'($urandom_range(21, 64));
			end else begin
				size = $urandom_range(0, 1) ? gmp_pkg::CFG_W'(0) :
					gmp_pkg::CFG_W'($urandom_range(65, 127));
			end
			eff = side_of(size);
			if (eff * eff <= 400 && $urandom_range(0, 4) != 0) begin
				boards = 400 / (eff * eff);
				boards = $urandom_range(1, boards > 3 ? 3 : boards);
				count = boards * eff * eff;
			end else begin
				count = $urandom_range(1, eff * eff < 3 * eff ? eff * eff : 3 * eff);
			end
			write_size(size);
			if (first_phase) begin
				tx_gap_max = 0;
				rx_gap_max = 0;
				hold_req = 1'b1;
				first_phase = 1'b0;
			end else begin
				tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
				rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			end
			for (int j = 0; j < count; j++) begin
				push_cell(rand_profit(), 1'b0, none);
			end
		end

		write_size(gmp_pkg::CFG_W'(FULL_SIDE));
		tx_gap_max = 0;
		rx_gap_max = 0;
		for (int j = 0; j < FULL_SIDE * FULL_SIDE; j++) begin
			push_cell(16'hFFFF, 1'b0, none);
		end
		item_ch.valid <= 1'b0;

		while (pending_scores.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (errors == 0 && pending_scores.size() == 0) begin
			$display("grid_max_path_sum_dp_unit: match");
		end else begin
			$display("grid_max_path_sum_dp_unit: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire
